// File: src/lts_pkg.sv
// Shared types and constants for the leakage transition sampler.
// No dependencies.
`timescale 1ns / 1ps
package lts_pkg;
  localparam int QUBITS = 2;
  localparam int LEVEL_BITS = 2;
  localparam int ENTRIES_PER_BUCKET = 16;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int STATUS_BITS = QUBITS * LEVEL_BITS;
  localparam int PAULI_BITS = 2 * QUBITS;
  localparam int NUM_BUCKETS = 1 << STATUS_BITS;
  localparam int WEIGHT_BITS = WEIGHT_FRAC_BITS + 1;
  localparam int SLOT_BITS = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) : 1;
  localparam int FILL_BITS = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int ADDR_BITS = STATUS_BITS + SLOT_BITS;
  localparam int NUM_ENTRIES = NUM_BUCKETS << SLOT_BITS;
  localparam int RANDOM_BITS = 16;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << WEIGHT_FRAC_BITS;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0, KIND_SAMPLE = 2'd1, KIND_QUERY = 2'd2, KIND_CHECK = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_OVER = 3'd1, ST_FULL = 3'd2, ST_NONE = 3'd3,
    ST_SUM = 3'd4, ST_PAULI = 3'd5
  } status_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] target;
    logic [PAULI_BITS-1:0]  pauli;
    logic [WEIGHT_BITS-1:0] weight;
  } entry_t;

  // Pauli must be I on every qubit where either level is nonzero.
  function automatic logic pauli_ok(input logic [STATUS_BITS-1:0] from_lv,
                                    input logic [STATUS_BITS-1:0] to_lv,
                                    input logic [PAULI_BITS-1:0] pw);
    logic ok;
    ok = 1'b1;
    for (int q = 0; q < QUBITS; q++) begin
      if ((from_lv[q*LEVEL_BITS +: LEVEL_BITS] != '0 ||
           to_lv[q*LEVEL_BITS +: LEVEL_BITS] != '0) && pw[2*q +: 2] != 2'd0)
        ok = 1'b0;
    end
    return ok;
  endfunction
endpackage

// File: src/lts_entry_ram.sv
// Entry store: one write port, one registered read port.
// Depends on lts_pkg.
`timescale 1ns / 1ps
module lts_entry_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [lts_pkg::ADDR_BITS-1:0] waddr,
  input  lts_pkg::entry_t               wdata,
  input  logic [lts_pkg::ADDR_BITS-1:0] raddr,
  output lts_pkg::entry_t               rdata
);
  lts_pkg::entry_t mem [lts_pkg::NUM_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/leakage_transition_sampler_unit.sv
// Leakage transition sampler: bucket table in flops, entries in a synchronous RAM.
// Check walks every bucket at one entry per cycle, stopping at the first bucket
// whose total is wrong or entry whose Pauli is illegal.
// One request at a time, next accepted only after the result is taken; result held.
// Synchronous reset clears bucket fill, total and used bits; entries need no clearing.
// Depends on lts_pkg and lts_entry_ram.
`timescale 1ns / 1ps
module leakage_transition_sampler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [3:0]  from_status,
  input  logic [3:0]  dest_status,
  input  logic [3:0]  pauli_word,
  input  logic [16:0] weight_in,
  input  logic [15:0] random_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [3:0]  chosen_status,
  output logic [3:0]  chosen_pauli,
  output logic [16:0] weight_out
);
  localparam int SB = lts_pkg::STATUS_BITS;
  localparam int WB = lts_pkg::WEIGHT_BITS;
  localparam int FB = lts_pkg::FILL_BITS;
  localparam int LB = lts_pkg::SLOT_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_READ = 6'b000010, S_EVAL = 6'b000100,
    S_MUL = 6'b001000, S_WRITE = 6'b010000, S_DONE = 6'b100000
  } state_t;

  state_t state;
  logic [FB-1:0] fill [lts_pkg::NUM_BUCKETS];
  logic [WB-1:0] total [lts_pkg::NUM_BUCKETS];
  logic [lts_pkg::NUM_BUCKETS-1:0] used;

  logic [1:0] kind_r;
  logic [SB-1:0] bucket, to_r;
  logic [lts_pkg::PAULI_BITS-1:0] pw_r;
  logic [WB-1:0] w_r;
  logic [15:0] rnd_r;
  logic [FB-1:0] idx;       // slot being read
  logic [WB+1:0] run;
  logic [WB-1:0] target_val;
  logic found;
  logic [LB-1:0] hit_slot;
  logic [WB-1:0] merge_weight;

  logic ram_we;
  logic [lts_pkg::ADDR_BITS-1:0] ram_waddr, ram_raddr;
  lts_pkg::entry_t ram_wdata, ram_rdata;

  lts_entry_ram u_ram (.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
                       .raddr(ram_raddr), .rdata(ram_rdata));

  logic [FB-1:0] cur_fill;
  logic [FB-1:0] idx_rd;
  logic [WB:0]   add_sum;
  logic [WB+1:0] run_next;
  logic [WB+15:0] prod;
  assign cur_fill  = fill[bucket];
  assign add_sum   = {1'b0, total[bucket]} + {1'b0, w_r};
  assign run_next  = run + (WB+2)'(ram_rdata.weight);
  assign prod      = {{WB{1'b0}}, rnd_r} * {16'b0, total[bucket]};
  // while walking, fetch the following slot so data arrives one entry per cycle
  assign idx_rd    = (state == S_EVAL) ? idx + 1'b1 : idx;
  assign ram_raddr = {bucket, idx_rd[LB-1:0]};
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {bucket, cur_fill[LB-1:0]};
    ram_wdata = '{target: to_r, pauli: pw_r, weight: w_r};
    if (state == S_WRITE && kind_r == lts_pkg::KIND_ADD &&
        (found || cur_fill != FB'(lts_pkg::ENTRIES_PER_BUCKET))) begin
      ram_we = 1'b1;
      if (found) begin
        ram_waddr = {bucket, hit_slot};
        ram_wdata.weight = merge_weight;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      used <= '0;
      for (int i = 0; i < lts_pkg::NUM_BUCKETS; i++) begin
        fill[i] <= '0;
        total[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= kind; to_r <= dest_status; pw_r <= pauli_word;
            w_r <= weight_in; rnd_r <= random_word;
            bucket <= (kind == lts_pkg::KIND_CHECK) ? '0 : from_status;
            idx <= '0; run <= '0; found <= 1'b0;
            status <= lts_pkg::ST_OK; chosen_status <= '0; chosen_pauli <= '0;
            weight_out <= '0;
            state <= (kind == lts_pkg::KIND_SAMPLE) ? S_MUL : S_READ;
          end
        end
        S_MUL: begin
          target_val <= prod[WB+15:16];
          state <= S_READ;
        end
        S_READ: begin
          // RAM address settles this cycle; data is read in EVAL
          if (kind_r == lts_pkg::KIND_ADD) begin
            used[bucket] <= 1'b1;
            if (add_sum > (WB+1)'(lts_pkg::WEIGHT_ONE)) begin
              status <= lts_pkg::ST_OVER; state <= S_DONE;
            end else if (cur_fill == '0) begin
              state <= S_WRITE;
            end else state <= S_EVAL;
          end else if (kind_r == lts_pkg::KIND_CHECK) begin
            if (!used[bucket]) begin
              if (bucket == SB'(lts_pkg::NUM_BUCKETS - 1)) state <= S_DONE;
              else bucket <= bucket + 1'b1;
            end else if (total[bucket] != lts_pkg::WEIGHT_ONE) begin
              status <= lts_pkg::ST_SUM; state <= S_DONE;
            end else if (cur_fill == '0) begin
              if (bucket == SB'(lts_pkg::NUM_BUCKETS - 1)) state <= S_DONE;
              else bucket <= bucket + 1'b1;
            end else state <= S_EVAL;
          end else if (cur_fill == '0) begin
            if (kind_r == lts_pkg::KIND_SAMPLE) status <= lts_pkg::ST_NONE;
            state <= S_DONE;
          end else state <= S_EVAL;
        end
        S_EVAL: begin
          logic last;
          logic hit;
          last = (idx + 1'b1 == cur_fill);
          hit  = (ram_rdata.target == to_r) && (ram_rdata.pauli == pw_r);
          idx <= idx + 1'b1;
          state <= S_READ;
          unique case (kind_r)
            lts_pkg::KIND_ADD: begin
              if (hit) begin
                found <= 1'b1; hit_slot <= idx[LB-1:0];
                merge_weight <= WB'(ram_rdata.weight + w_r);
                state <= S_WRITE;
              end else if (last) state <= S_WRITE;
              else state <= S_EVAL;
            end
            lts_pkg::KIND_QUERY: begin
              if (hit) begin weight_out <= ram_rdata.weight; state <= S_DONE; end
              else if (last) state <= S_DONE;
              else state <= S_EVAL;
            end
            lts_pkg::KIND_SAMPLE: begin
              run <= run_next;
              if (cur_fill == FB'(1) || run_next >= (WB+2)'(target_val) || last) begin
                chosen_status <= ram_rdata.target; chosen_pauli <= ram_rdata.pauli;
                state <= S_DONE;
              end else state <= S_EVAL;
            end
            default: begin
              if (!lts_pkg::pauli_ok(bucket, ram_rdata.target, ram_rdata.pauli)) begin
                status <= lts_pkg::ST_PAULI; state <= S_DONE;
              end else if (last) begin
                idx <= '0;
                if (bucket == SB'(lts_pkg::NUM_BUCKETS - 1)) state <= S_DONE;
                else begin bucket <= bucket + 1'b1; state <= S_READ; end
              end else state <= S_EVAL;
            end
          endcase
        end
        S_WRITE: begin
          // merged weight was captured when the match was found
          if (!found && cur_fill == FB'(lts_pkg::ENTRIES_PER_BUCKET)) begin
            status <= lts_pkg::ST_FULL;
          end else begin
            total[bucket] <= add_sum[WB-1:0];
            if (!found) fill[bucket] <= cur_fill + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // write only happens in its own state and never to a full bucket unless merging
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (found || cur_fill < FB'(lts_pkg::ENTRIES_PER_BUCKET) || status != lts_pkg::ST_OK))
    else $error("append beyond bucket");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_DONE) else $error("result outside done state");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !out_valid) else $error("stale result");
endmodule
